// File: design/sequence_record_splitter_assert.svh
// Assertion macros used by the checker file srs_checker.sv.
`ifndef SEQUENCE_RECORD_SPLITTER_ASSERT_SVH
`define SEQUENCE_RECORD_SPLITTER_ASSERT_SVH

// Clocked check, muted while reset is asserted.
`define SRS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds across reset.
`define SRS_ASSERT_ANY(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/srs_pkg.sv
package srs_pkg;

    localparam int COUNT_BITS_DEF = 32;

    // Output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Characters
    localparam logic [7:0] CH_GT = 8'h3E;  // '>'
    localparam logic [7:0] CH_QM = 8'h3F;  // '?'
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // Line phase
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_GT    = 2'd1;
    localparam logic [1:0] PH_IN    = 2'd2;

    // Line class
    localparam logic [1:0] CL_DATA  = 2'd0;
    localparam logic [1:0] CL_OTHER = 2'd1;
    localparam logic [1:0] CL_DEF   = 2'd2;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_marker;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] record_begin;
        logic [31:0] data_begin;
        logic [31:0] record_end;
        logic [31:0] first_line_index;
        logic [31:0] residue_count;
        logic [31:0] line_count;
        logic        has_header;
        logic        last_of_run;
    } t_out_beat;

endpackage

// File: design/sequence_record_splitter.sv
// Channel   Direction  Signals                                 Beat
// input     in         i_in_valid / o_in_ready / i_in_beat     one text byte or end marker
// result    out        o_out_valid / i_out_ready / o_out_beat  one record descriptor
// config    in         i_cfg_valid / o_cfg_ready / i_cfg_data  delta_mode bit
//
// One input beat per cycle sustained while two queue entries are free; an accepted
// beat goes through the input register, then the 4-entry result queue.
// An end marker may push two results in one cycle; the queue holds that and
// keeps the input open as long as at least two entries are free.
// i_rst_n is synchronous, active low; it clears all stream state and delta_mode.
// Result stalls back up into the input only once the queue has under two free slots.
module sequence_record_splitter #(
    parameter int COUNT_BITS = srs_pkg::COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte stream
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  srs_pkg::t_in_beat  i_in_beat,
    // records
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output srs_pkg::t_out_beat o_out_beat,
    // delta_mode register
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);
    import srs_pkg::*;

    // config register, always writable
    logic r_delta_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_delta_mode <= i_cfg_data;
        end
    end

    // input register
    logic     r_in_valid;
    t_in_beat r_in_beat;
    logic     step;

    // result queue
    t_out_beat            r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [FIFO_CW-1:0]   r_count, n_count;
    logic [1:0]           push_valid;
    t_out_beat            push_beat [2];
    logic                 pop;
    logic [FIFO_CW-1:0]   push_n;

    // advance only with room for the worst case of two results
    assign step       = r_in_valid && (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_beat <= i_in_beat;
        end
    end

    srs_core #(
        .CountBits (COUNT_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_beat       (r_in_beat),
        .i_delta_mode (r_delta_mode),
        .o_res_valid  (push_valid),
        .o_res        (push_beat)
    );

    assign pop         = o_out_valid && i_out_ready;
    assign o_out_valid = (r_count != '0);
    assign o_out_beat  = r_fifo[r_rd_ptr];

    // second result valid implies the first
    assign push_n  = FIFO_CW'(push_valid[0]) + FIFO_CW'(push_valid[1]);
    assign n_count = r_count + push_n - FIFO_CW'(pop);

    always_ff @(posedge i_clk) begin
        if (push_valid[0]) begin
            r_fifo[r_wr_ptr] <= push_beat[0];
        end
        if (push_valid[1]) begin
            r_fifo[r_wr_ptr + FIFO_AW'(1)] <= push_beat[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(push_n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

// File: design/srs_core.sv
module srs_core #(
    parameter int CountBits = srs_pkg::COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  srs_pkg::t_in_beat i_beat,
    input  logic              i_delta_mode,
    output logic [1:0]        o_res_valid,
    output srs_pkg::t_out_beat o_res [2]
);
    import srs_pkg::*;

    typedef logic [CountBits-1:0] t_cnt;

    function automatic t_cnt sat_inc(input t_cnt v);
        return (&v) ? v : t_cnt'(v + 1'b1);
    endfunction

    function automatic logic [31:0] clip_out(input t_cnt v);
        logic [63:0] w;
        w = 64'(v);
        return (|w[63:32]) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    t_cnt       r_pos, r_line_no, r_line_begin;
    logic [1:0] r_phase, r_class;
    logic       r_cr, r_gap;
    t_cnt       r_begin, r_data_begin, r_first, r_res, r_lines;
    logic       r_hdr;

    t_cnt       n_pos, n_line_no, n_line_begin;
    logic [1:0] n_phase, n_class;
    logic       n_cr, n_gap;
    t_cnt       n_begin, n_data_begin, n_first, n_res, n_lines;
    logic       n_hdr;

    // Defline handling, always evaluated on the current state.
    logic       td_cont, td_emit;
    t_cnt       td_begin, td_data_begin, td_first, td_res, td_lines;
    logic       td_hdr;
    logic [1:0] td_class;

    // Residue update for one data byte.
    logic       db_cr;
    t_cnt       db_res, db_res1;

    logic       emit_a, emit_b;
    t_out_beat  rec_a, rec_b;
    logic [7:0] b;

    assign b = i_beat.byte_value;

    always_comb begin
        td_cont = i_delta_mode && r_gap;
        td_emit = !td_cont && (r_lines != '0);
        if (td_cont) begin
            td_begin      = r_begin;
            td_data_begin = r_data_begin;
            td_first      = r_first;
            td_res        = r_res;
            td_lines      = sat_inc(r_lines);
            td_hdr        = r_hdr;
            td_class      = CL_OTHER;
        end else begin
            td_begin      = r_line_begin;
            td_data_begin = r_line_begin;
            td_first      = r_line_no;
            td_res        = '0;
            td_lines      = t_cnt'(1);
            td_hdr        = 1'b1;
            td_class      = CL_DEF;
        end
    end

    always_comb begin
        db_res1 = r_cr ? sat_inc(r_res) : r_res;
        db_cr   = (b == CH_CR);
        db_res  = db_cr ? db_res1 : sat_inc(db_res1);
    end

    // Previous record, closed by a defline.
    always_comb begin
        rec_a.record_begin     = clip_out(r_begin);
        rec_a.data_begin       = clip_out(r_data_begin);
        rec_a.record_end       = clip_out(r_line_begin);
        rec_a.first_line_index = clip_out(r_first);
        rec_a.residue_count    = clip_out(r_res);
        rec_a.line_count       = clip_out(r_lines);
        rec_a.has_header       = r_hdr;
        rec_a.last_of_run      = 1'b0;
    end

    always_comb begin
        n_pos        = r_pos;
        n_line_no    = r_line_no;
        n_line_begin = r_line_begin;
        n_phase      = r_phase;
        n_class      = r_class;
        n_cr         = r_cr;
        n_gap        = r_gap;
        n_begin      = r_begin;
        n_data_begin = r_data_begin;
        n_first      = r_first;
        n_res        = r_res;
        n_lines      = r_lines;
        n_hdr        = r_hdr;
        emit_a       = 1'b0;
        emit_b       = 1'b0;
        rec_b        = '0;

        if (i_beat.end_marker) begin
            if (r_phase == PH_GT) begin
                emit_a       = td_emit;
                n_gap        = 1'b0;
                n_begin      = td_begin;
                n_data_begin = td_data_begin;
                n_first      = td_first;
                n_res        = td_res;
                n_lines      = td_lines;
                n_hdr        = td_hdr;
                n_class      = td_class;
            end
            if (r_phase != PH_START) begin
                if (n_class == CL_DATA && r_cr) begin
                    n_res = sat_inc(n_res);
                end
                if (n_class == CL_DEF) begin
                    n_data_begin = r_pos;
                end
            end
            emit_b                 = (n_lines != '0);
            rec_b.record_begin     = clip_out(n_begin);
            rec_b.data_begin       = clip_out(n_data_begin);
            rec_b.record_end       = clip_out(r_pos);
            rec_b.first_line_index = clip_out(n_first);
            rec_b.residue_count    = clip_out(n_res);
            rec_b.line_count       = clip_out(n_lines);
            rec_b.has_header       = n_hdr;
            rec_b.last_of_run      = 1'b1;
            // back to the start of a new text
            n_pos        = '0;
            n_line_no    = '0;
            n_line_begin = '0;
            n_phase      = PH_START;
            n_class      = CL_DATA;
            n_cr         = 1'b0;
            n_gap        = 1'b0;
            n_begin      = '0;
            n_data_begin = '0;
            n_first      = '0;
            n_res        = '0;
            n_lines      = '0;
            n_hdr        = 1'b0;
        end else begin
            n_pos = sat_inc(r_pos);
            unique case (r_phase)
                PH_START: begin
                    n_line_begin = r_pos;
                    if (b == CH_GT) begin
                        n_phase = PH_GT;
                        n_class = CL_OTHER;
                    end else begin
                        n_class = CL_DATA;
                        n_lines = sat_inc(r_lines);
                        if (b == CH_LF) begin
                            n_line_no = sat_inc(r_line_no);
                            n_phase   = PH_START;
                            n_cr      = 1'b0;
                        end else begin
                            n_phase = PH_IN;
                            n_cr    = db_cr;
                            n_res   = db_res;
                        end
                    end
                end
                PH_GT: begin
                    if (b == CH_QM) begin
                        n_gap   = 1'b1;
                        n_class = CL_OTHER;
                        n_lines = sat_inc(r_lines);
                        n_phase = PH_IN;
                    end else begin
                        emit_a       = td_emit;
                        n_gap        = 1'b0;
                        n_begin      = td_begin;
                        n_data_begin = td_data_begin;
                        n_first      = td_first;
                        n_res        = td_res;
                        n_lines      = td_lines;
                        n_hdr        = td_hdr;
                        n_class      = td_class;
                        if (b == CH_LF) begin
                            if (td_class == CL_DEF) begin
                                n_data_begin = sat_inc(r_pos);
                            end
                            n_line_no = sat_inc(r_line_no);
                            n_phase   = PH_START;
                            n_class   = CL_DATA;
                            n_cr      = 1'b0;
                        end else begin
                            n_phase = PH_IN;
                        end
                    end
                end
                default: begin
                    if (b == CH_LF) begin
                        if (r_class == CL_DEF) begin
                            n_data_begin = sat_inc(r_pos);
                        end
                        n_line_no = sat_inc(r_line_no);
                        n_phase   = PH_START;
                        n_class   = CL_DATA;
                        n_cr      = 1'b0;
                    end else if (r_class == CL_DATA) begin
                        n_cr  = db_cr;
                        n_res = db_res;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_res_valid[0] = i_step && (emit_a || emit_b);
        o_res_valid[1] = i_step && emit_a && emit_b;
        if (emit_a) begin
            o_res[0]             = rec_a;
            o_res[0].last_of_run = !emit_b;
        end else begin
            o_res[0] = rec_b;
        end
        o_res[1] = rec_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_line_no    <= '0;
            r_line_begin <= '0;
            r_phase      <= PH_START;
            r_class      <= CL_DATA;
            r_cr         <= 1'b0;
            r_gap        <= 1'b0;
            r_begin      <= '0;
            r_data_begin <= '0;
            r_first      <= '0;
            r_res        <= '0;
            r_lines      <= '0;
            r_hdr        <= 1'b0;
        end else if (i_step) begin
            r_pos        <= n_pos;
            r_line_no    <= n_line_no;
            r_line_begin <= n_line_begin;
            r_phase      <= n_phase;
            r_class      <= n_class;
            r_cr         <= n_cr;
            r_gap        <= n_gap;
            r_begin      <= n_begin;
            r_data_begin <= n_data_begin;
            r_first      <= n_first;
            r_res        <= n_res;
            r_lines      <= n_lines;
            r_hdr        <= n_hdr;
        end
    end

endmodule

// File: design/srs_checker.sv
`include "sequence_record_splitter_assert.svh"

module srs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input srs_pkg::t_out_beat o_out_beat
);
    import srs_pkg::*;

    `SRS_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "result dropped while stalled")
    `SRS_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_out_beat), "result changed while stalled")
    `SRS_ASSERT_ANY(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")
    `SRS_ASSERT(a_pair_follows, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_out_beat.last_of_run |=> o_out_valid, "second result of a pair missing")
    `SRS_ASSERT(a_pair_adjacent, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_out_beat.last_of_run |=> o_out_beat.record_begin == $past(o_out_beat.record_end), "paired records not adjacent")

endmodule

bind sequence_record_splitter srs_checker u_srs_checker (.*);

// File: verif/sequence_record_splitter_checker.sv
`timescale 1ns / 100ps

module sequence_record_splitter_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  srs_pkg::t_in_beat  i_in_beat,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  srs_pkg::t_out_beat i_out_beat,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic               i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending_count
);

    import srs_pkg::*;

    localparam int          CNT_W       = COUNT_BITS_DEF;
    localparam logic [63:0] CNT_MAX     = {64{1'b1}} >> (64 - CNT_W);

    // Splitter state, counters kept wide and saturated at CNT_MAX
    bit          delta_mode;
    logic [63:0] byte_pos, line_num, line_start;
    logic [1:0]  phase, lclass;
    bit          cr_pending, gap_seen;
    logic [63:0] rec_begin, rec_data_begin, rec_first_line, rec_residues, rec_lines;
    bit          rec_header;

    t_out_beat   expected_records[$];
    t_out_beat   step_recs[2];
    int          step_n;
    int          fail_count = 0;

    function automatic logic [63:0] sat_inc(logic [63:0] v);
        return (v >= CNT_MAX) ? CNT_MAX : v + 64'd1;
    endfunction

    function automatic logic [31:0] clip32(logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    task automatic report_mismatch(string msg);
        fail_count++;
        $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task automatic reset_text_state();
        byte_pos       = '0;
        line_num       = '0;
        line_start     = '0;
        phase          = PH_START;
        lclass         = CL_DATA;
        cr_pending     = 1'b0;
        gap_seen       = 1'b0;
        rec_begin      = '0;
        rec_data_begin = '0;
        rec_first_line = '0;
        rec_residues   = '0;
        rec_lines      = '0;
        rec_header     = 1'b0;
    endtask

    task automatic push_record(logic [63:0] rec_end);
        t_out_beat r;
        r.record_begin     = clip32(rec_begin);
        r.data_begin       = clip32(rec_data_begin);
        r.record_end       = clip32(rec_end);
        r.first_line_index = clip32(rec_first_line);
        r.residue_count    = clip32(rec_residues);
        r.line_count       = clip32(rec_lines);
        r.has_header       = rec_header;
        r.last_of_run      = 1'b0;
        step_recs[step_n]  = r;
        step_n++;
    endtask

    // '>' line that is known not to be a gap line
    task automatic open_defline();
        if (delta_mode && gap_seen) begin
            gap_seen  = 1'b0;
            lclass    = CL_OTHER;
            rec_lines = sat_inc(rec_lines);
        end else begin
            gap_seen = 1'b0;
            if (rec_lines > 0) begin
                push_record(line_start);
            end
            rec_begin      = line_start;
            rec_data_begin = line_start;
            rec_first_line = line_num;
            rec_residues   = '0;
            rec_lines      = 64'd1;
            rec_header     = 1'b1;
            lclass         = CL_DEF;
        end
    endtask

    task automatic close_line(logic [63:0] pos);
        if (lclass == CL_DEF) begin
            rec_data_begin = sat_inc(pos);
        end
        line_num   = sat_inc(line_num);
        phase      = PH_START;
        lclass     = CL_DATA;
        cr_pending = 1'b0;
    endtask

    task automatic count_data_byte(logic [7:0] b);
        if (cr_pending) begin
            cr_pending   = 1'b0;
            rec_residues = sat_inc(rec_residues);
        end
        if (b == CH_CR) begin
            cr_pending = 1'b1;
        end else begin
            rec_residues = sat_inc(rec_residues);
        end
    endtask

    task automatic predict_records(t_in_beat beat);
        logic [63:0] pos;
        logic [7:0]  b;
        t_out_beat   r;
        pos    = byte_pos;
        b      = beat.byte_value;
        step_n = 0;
        if (beat.end_marker) begin
            if (phase == PH_GT) begin
                open_defline();
            end
            if (phase != PH_START) begin
                if (lclass == CL_DATA && cr_pending) begin
                    rec_residues = sat_inc(rec_residues);
                end
                if (lclass == CL_DEF) begin
                    rec_data_begin = pos;
                end
            end
            if (rec_lines > 0) begin
                push_record(pos);
            end
            reset_text_state();
        end else begin
            if (phase == PH_START) begin
                line_start = pos;
                if (b == CH_GT) begin
                    phase  = PH_GT;
                    lclass = CL_OTHER;
                end else begin
                    lclass    = CL_DATA;
                    rec_lines = sat_inc(rec_lines);
                    if (b == CH_LF) begin
                        close_line(pos);
                    end else begin
                        phase = PH_IN;
                        count_data_byte(b);
                    end
                end
            end else if (phase == PH_GT) begin
                if (b == CH_QM) begin
                    gap_seen  = 1'b1;
                    lclass    = CL_OTHER;
                    rec_lines = sat_inc(rec_lines);
                    phase     = PH_IN;
                end else begin
                    open_defline();
                    if (b == CH_LF) begin
                        close_line(pos);
                    end else begin
                        phase = PH_IN;
                    end
                end
            end else begin
                if (b == CH_LF) begin
                    close_line(pos);
                end else if (lclass == CL_DATA) begin
                    count_data_byte(b);
                end
            end
            byte_pos = sat_inc(pos);
        end
        for (int k = 0; k < step_n; k++) begin
            r             = step_recs[k];
            r.last_of_run = (k == step_n - 1);
            expected_records.push_back(r);
        end
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
        end
    endtask

    task automatic check_record(t_out_beat got);
        t_out_beat want;
        if (expected_records.size() == 0) begin
            report_mismatch($sformatf("unexpected record beat: begin %0d end %0d",
                                      got.record_begin, got.record_end));
            return;
        end
        want = expected_records.pop_front();
        check_field("record_begin", got.record_begin, want.record_begin);
        check_field("data_begin", got.data_begin, want.data_begin);
        check_field("record_end", got.record_end, want.record_end);
        check_field("first_line_index", got.first_line_index, want.first_line_index);
        check_field("residue_count", got.residue_count, want.residue_count);
        check_field("line_count", got.line_count, want.line_count);
        check_field("has_header", {31'd0, got.has_header}, {31'd0, want.has_header});
        check_field("last_of_run", {31'd0, got.last_of_run}, {31'd0, want.last_of_run});
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_text_state();
            delta_mode = 1'b0;
            expected_records.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                delta_mode = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                predict_records(i_in_beat);
            end
            if (i_out_valid && i_out_ready) begin
                check_record(i_out_beat);
            end
        end
        o_pending_count <= expected_records.size();
        o_fail_count    <= fail_count;
    end

endmodule

// File: verif/sequence_record_splitter_tb.sv
`timescale 1ns / 100ps

module sequence_record_splitter_tb;

    import srs_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 11;
    localparam int IDLE_PCT      = 14;      // idle cycles per hundred, each side
    localparam int SETTLE_CYCLES = 4;       // input register and result queue, plus margin
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int PHASE_ITEMS   = 245;     // random beats per phase
    localparam int NUM_PHASES    = 4;
    localparam int LIMIT_NS      = 3_000_000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_beat  i_in_beat   = '0;
    logic      i_out_ready = 1'b0;
    logic      i_cfg_valid = 1'b0;
    logic      i_cfg_data  = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_beat o_out_beat;
    logic      o_cfg_ready;

    int        fail_count;
    int        pending_count;

    // Knobs shared between the sender, the receiver and the phase sequencer
    bit        tx_idle_on    = 1'b1;
    bit        rx_idle_on    = 1'b1;
    bit        hold_request  = 1'b0;
    int        item_count    = 0;

    always #CLK_HALF i_clk = ~i_clk;

    sequence_record_splitter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Watches all three channels, predicts the records and compares them
    sequence_record_splitter_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_in_beat       (i_in_beat),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_out_beat      (o_out_beat),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    // Offer one beat and block until it is taken. Called right after a rising
    // edge; valid only drops when an idle gap is actually inserted, so back-to-back
    // beats never see a low/high pair in the same step.
    task automatic send_beat(t_in_beat beat);
        if (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(99) < IDLE_PCT);
        end
        i_in_beat  <= beat;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        item_count++;
    endtask

    task automatic send_byte(logic [7:0] b);
        t_in_beat beat;
        beat.byte_value = b;
        beat.end_marker = 1'b0;
        send_beat(beat);
    endtask

    // End marker: the byte lane is don't-care, so it carries noise
    task automatic send_end();
        t_in_beat beat;
        beat.byte_value = 8'($urandom_range(255));
        beat.end_marker = 1'b1;
        send_beat(beat);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    // Mostly sequence letters, with the odd CR, '>', '?' or arbitrary byte
    function automatic logic [7:0] body_char();
        string bases = "ACGTNacgtn";
        case ($urandom_range(19))
            0:       return CH_CR;
            1:       return 8'($urandom_range(255));
            2:       return CH_GT;
            3:       return CH_QM;
            default: return bases[$urandom_range(9)];
        endcase
    endfunction

    // prefix "" = data line, ">" = defline, ">?" = gap line
    task automatic send_line(string prefix, int body_len, bit with_cr, bit with_lf);
        send_text(prefix);
        repeat (body_len) begin
            send_byte(body_char());
        end
        if (with_cr) begin
            send_byte(CH_CR);
        end
        if (with_lf) begin
            send_byte(CH_LF);
        end
    endtask

    // One text: mostly well-formed records with random content, some noise
    task automatic gen_text();
        int nb;
        if ($urandom_range(9) == 0) begin
            // Noise burst, biased toward the bytes the line parser reacts to
            nb = $urandom_range(1, 24);
            repeat (nb) begin
                case ($urandom_range(5))
                    0:       send_byte(CH_GT);
                    1:       send_byte(CH_QM);
                    2:       send_byte(CH_LF);
                    3:       send_byte(CH_CR);
                    4:       send_byte(8'($urandom_range(255)));
                    default: send_byte("A");
                endcase
            end
            // sometimes no end marker: the next text runs on from here
            if ($urandom_range(3) != 0) begin
                send_end();
            end
            return;
        end
        // headerless lead-in
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                send_line("", $urandom_range(0, 10), $urandom_range(3) == 0, 1'b1);
            end
        end
        repeat ($urandom_range(1, 4)) begin
            // gap lines ahead of the defline matter in delta mode
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 2)) begin
                    send_line(">?", $urandom_range(0, 5), 1'b0, 1'b1);
                end
            end
            // lone '>' now and then
            send_line(">", ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 8),
                      $urandom_range(3) == 0, 1'b1);
            repeat ($urandom_range(0, 3)) begin
                send_line("", $urandom_range(0, 12), $urandom_range(3) == 0, 1'b1);
            end
        end
        // unterminated last line, closed by the end marker
        case ($urandom_range(4))
            0:       send_line("", $urandom_range(1, 6), $urandom_range(1), 1'b0);
            1:       send_line(">", $urandom_range(0, 3), 1'b0, 1'b0);
            default: ;
        endcase
        send_end();
    endtask

    // Stop offering, wait for every expected record, then let the pipe settle
    task automatic wait_drained();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (pending_count != 0 && guard < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write, only with the block idle
    task automatic write_delta_mode(bit value);
        wait_drained();
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver: random ready, plus one long hold-off on request
    initial begin
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                i_out_ready <= !rx_idle_on || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int phase_goal;
        bit mode;
        bit hold_done;
        hold_done = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, delta mode off after reset
        send_end();                         // empty text: no record
        send_text("A\015B\n>");             // CR inside a line, then a lone '>'
        send_end();                         // ... decided by the marker: two records
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_CR);                   // CR right before the end marker
        send_end();
        send_text(">\n>?\nC\015\n");        // lone defline, gap line, CRLF data
        send_end();

        // Directed, delta mode on: defline after a gap continues the record
        write_delta_mode(1'b1);
        send_text(">?\n>b\nC");
        send_end();

        // Random phases: mode off (with the hold-off), on without idling,
        // on, then either
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       mode = 1'b0;
                3:       mode = 1'($urandom_range(1));
                default: mode = 1'b1;
            endcase
            write_delta_mode(mode);
            tx_idle_on = (ph != 1);
            rx_idle_on = (ph != 1);
            phase_goal = item_count + PHASE_ITEMS;
            while (item_count < phase_goal) begin
                // receiver stops a while into the first phase; sender keeps going
                if (ph == 0 && !hold_done && item_count > phase_goal - PHASE_ITEMS + 60) begin
                    hold_request = 1'b1;
                    hold_done    = 1'b1;
                end
                gen_text();
            end
        end

        wait_drained();
        if (fail_count == 0 && pending_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
